/* rtl/hsv_color_key_centroid_assert.svh */
// Assertion helpers for the RTL files; included by hsvck_ctrl.
`ifndef HSV_COLOR_KEY_CENTROID_ASSERT_SVH
`define HSV_COLOR_KEY_CENTROID_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HSVCK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HSVCK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hsvck_pkg.sv */
package hsvck_pkg;

  // Field widths.
  localparam int unsigned HUE_W    = 8;
  localparam int unsigned SAT_W    = 8;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned WEIGHT_W = 9;
  localparam int unsigned SUM_W    = 34;
  localparam int unsigned CNT_W    = 23;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Frame limits and derived coordinate clamps.
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned COORD_MAX  = (1 << COORD_W) - 1;
  localparam int unsigned COL_TOP_I  =
      (MAX_WIDTH - 1 > COORD_MAX) ? COORD_MAX : MAX_WIDTH - 1;
  localparam int unsigned ROW_TOP_I  =
      (MAX_HEIGHT - 1 > COORD_MAX) ? COORD_MAX : MAX_HEIGHT - 1;
  localparam logic [COORD_W-1:0] COL_TOP = COL_TOP_I[COORD_W-1:0];
  localparam logic [COORD_W-1:0] ROW_TOP = ROW_TOP_I[COORD_W-1:0];
  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  // Blend weight of one in Q1.8.
  localparam logic [WEIGHT_W-1:0] ALPHA_ONE = 9'd256;

  // One quotient bit per divide step.
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd3;

  // Configuration reset values.
  localparam logic [HUE_W-1:0]    HUE_LOW_RST  = 8'd180;
  localparam logic [HUE_W-1:0]    HUE_HIGH_RST = 8'd170;
  localparam logic [SAT_W-1:0]    SAT_THR_RST  = 8'd120;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST   = 9'd0;

  typedef enum logic [1:0] {
    S_RUN,
    S_DIV,
    S_MUL,
    S_SUM
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic load_pixel;
    logic div_step;
    logic mul_en;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic go_div;
  } dp_stat_t;

endpackage

/* rtl/hsv_color_key_centroid.sv */
// An accepted pixel's result is registered in the output register in the next cycle; a frame-end
// pixel with keyed pixels in the frame has its result after the divide, multiply and blend states.
// Throughput: one pixel per clock while the output slot is free, except such a frame-end pixel,
// which goes through its accept, 11 steps of the bit-serial mean divider, a multiply state and a
// blend state, with the input held off until the blend completes; an empty frame end passes like any other pixel.
// Reset (asynchronous, active low) clears sums, count and center, and loads register defaults.
module hsv_color_key_centroid import hsvck_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [HUE_W-1:0]      hue_i,
  input  logic [SAT_W-1:0]      saturation_i,
  input  logic [COORD_W-1:0]    col_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic                  frame_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  keyed_o,
  output logic [COORD_W-1:0]    center_col_o,
  output logic [COORD_W-1:0]    center_row_o,
  output logic                  center_updated_o,
  output logic                  frame_done_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for accept, divide, multiply and blend.
  hsvck_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Keying, accumulators, divider, blend and output item.
  hsvck_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .hue_i            (hue_i),
    .saturation_i     (saturation_i),
    .col_i            (col_i),
    .row_i            (row_i),
    .frame_end_i      (frame_end_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .keyed_o          (keyed_o),
    .center_col_o     (center_col_o),
    .center_row_o     (center_row_o),
    .center_updated_o (center_updated_o),
    .frame_done_o     (frame_done_o)
  );

endmodule

/* rtl/hsvck_ctrl.sv */
module hsvck_ctrl import hsvck_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

`include "hsv_color_key_centroid_assert.svh"

  ctrl_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              acc;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_RUN) && slot_free;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_RUN: begin
        if (acc && stat_i.go_div) begin
          state_d = S_DIV;
          step_d  = '0;
        end
      end
      S_DIV: begin
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SUM;
      end
      S_SUM: begin
        if (slot_free) begin
          state_d = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_RUN: begin
        cmd_o.accept     = acc;
        cmd_o.load_pixel = acc && !stat_i.go_div;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      S_SUM: begin
        cmd_o.finish = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // The output slot fills on a result and empties when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_pixel || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `HSVCK_ASSERT_IMP(a_no_accept_busy, state_q != S_RUN, !in_ready_o, "input taken while busy")
  `HSVCK_ASSERT_NXT(a_div_len, (state_q == S_DIV) && (step_q == LAST_STEP), state_q == S_MUL, "divide length wrong")
  `HSVCK_ASSERT_IMP(a_finish_slot, cmd_o.finish, !out_valid_q || out_ready_i, "frame result overwrites item")

endmodule

/* rtl/hsvck_dp.sv */
module hsvck_dp import hsvck_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [HUE_W-1:0]      hue_i,
  input  logic [SAT_W-1:0]      saturation_i,
  input  logic [COORD_W-1:0]    col_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic                  frame_end_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output logic                  keyed_o,
  output logic [COORD_W-1:0]    center_col_o,
  output logic [COORD_W-1:0]    center_row_o,
  output logic                  center_updated_o,
  output logic                  frame_done_o
);

  localparam int unsigned PROD_W = WEIGHT_W + COORD_W;

  logic [HUE_W-1:0]    hue_low_q, hue_high_q;
  logic [SAT_W-1:0]    sat_thr_q;
  logic [WEIGHT_W-1:0] weight_q;

  logic [SUM_W-1:0]   sum_col_q, sum_col_d, sum_row_q, sum_row_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SUM_W-1:0]   dsh_q;
  logic [COORD_W-1:0] qcol_q, qrow_q;
  logic [COORD_W-1:0] track_col_q, track_col_d, track_row_q, track_row_d;
  logic [PROD_W-1:0]  p_oc_q, p_mc_q, p_or_q, p_mr_q;
  logic               keyed_hold_q;
  logic               out_keyed_q, out_upd_q, out_done_q;

  logic               in_band, keyed_pix, add_en;
  logic [COORD_W-1:0] col_c, row_c;
  logic               ge_col, ge_row;
  logic [WEIGHT_W-1:0] alpha, alpha_inv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HUE_LOW_RST;
      hue_high_q <= HUE_HIGH_RST;
      sat_thr_q  <= SAT_THR_RST;
      weight_q   <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HUE_LOW:  hue_low_q  <= cfg_data_i[HUE_W-1:0];
        REG_HUE_HIGH: hue_high_q <= cfg_data_i[HUE_W-1:0];
        REG_SAT_THR:  sat_thr_q  <= cfg_data_i[SAT_W-1:0];
        REG_WEIGHT:   weight_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Key test: a straight band, or a wrapped one when the bounds do not rise.
  always_comb begin
    if (hue_low_q < hue_high_q) begin
      in_band = (hue_i >= hue_low_q) && (hue_i <= hue_high_q);
    end else begin
      in_band = (hue_i >= hue_low_q) || (hue_i <= hue_high_q);
    end
    keyed_pix = (saturation_i > sat_thr_q) && in_band;
  end

  // Coordinates beyond the frame are clamped to its last column or row.
  assign col_c  = (col_i > COL_TOP) ? COL_TOP : col_i;
  assign row_c  = (row_i > ROW_TOP) ? ROW_TOP : row_i;
  assign add_en = keyed_pix && (cnt_q != CNT_MAX);

  // Restoring divide: the sums act as remainders against the shifted count.
  assign ge_col = sum_col_q >= dsh_q;
  assign ge_row = sum_row_q >= dsh_q;

  // Accumulators: add on a keyed pixel until the count saturates, subtract during the divide, clear at the end.
  always_comb begin
    sum_col_d = sum_col_q;
    sum_row_d = sum_row_q;
    cnt_d     = cnt_q;
    if (cmd_i.accept && add_en) begin
      sum_col_d = sum_col_q + SUM_W'(col_c);
      sum_row_d = sum_row_q + SUM_W'(row_c);
      cnt_d     = cnt_q + 1'b1;
    end else if (cmd_i.div_step) begin
      if (ge_col) sum_col_d = sum_col_q - dsh_q;
      if (ge_row) sum_row_d = sum_row_q - dsh_q;
    end else if (cmd_i.finish) begin
      sum_col_d = '0;
      sum_row_d = '0;
      cnt_d     = '0;
    end
  end

  assign stat_o.go_div = frame_end_i && (cnt_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_col_q <= '0;
      sum_row_q <= '0;
      cnt_q     <= '0;
    end else begin
      sum_col_q <= sum_col_d;
      sum_row_q <= sum_row_d;
      cnt_q     <= cnt_d;
    end
  end

  // Divisor and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dsh_q        <= {cnt_d, {(SUM_W - CNT_W){1'b0}}} >> (SUM_W - CNT_W - (COORD_W - 1));
      keyed_hold_q <= keyed_pix;
    end else if (cmd_i.div_step) begin
      dsh_q  <= dsh_q >> 1;
      qcol_q <= {qcol_q[COORD_W-2:0], ge_col};
      qrow_q <= {qrow_q[COORD_W-2:0], ge_row};
    end
  end

  // Blend products: old center by one minus alpha, mean by alpha.
  assign alpha     = (weight_q > ALPHA_ONE) ? ALPHA_ONE : weight_q;
  assign alpha_inv = ALPHA_ONE - alpha;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_oc_q <= PROD_W'(alpha_inv) * PROD_W'(track_col_q);
      p_mc_q <= PROD_W'(alpha) * PROD_W'(qcol_q);
      p_or_q <= PROD_W'(alpha_inv) * PROD_W'(track_row_q);
      p_mr_q <= PROD_W'(alpha) * PROD_W'(qrow_q);
    end
  end

  // Round each term to nearest, add, and saturate.
  function automatic logic [COORD_W-1:0] blend_sum(logic [PROD_W-1:0] pa,
                                                   logic [PROD_W-1:0] pb);
    logic [PROD_W:0]     ra, rb;
    logic [PROD_W-7:0]   s;
    ra = {1'b0, pa} + (PROD_W+1)'(128);
    rb = {1'b0, pb} + (PROD_W+1)'(128);
    s  = {1'b0, ra[PROD_W:8]} + {1'b0, rb[PROD_W:8]};
    if (s > (PROD_W-6)'(COORD_MAX)) begin
      return COORD_W'(COORD_MAX);
    end
    return s[COORD_W-1:0];
  endfunction

  assign track_col_d = blend_sum(p_oc_q, p_mc_q);
  assign track_row_d = blend_sum(p_or_q, p_mr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_col_q <= '0;
      track_row_q <= '0;
    end else if (cmd_i.finish) begin
      track_col_q <= track_col_d;
      track_row_q <= track_row_d;
    end
  end

  // Output item flags; the center is read straight from the track registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pixel) begin
      out_keyed_q <= keyed_pix;
      out_upd_q   <= 1'b0;
      out_done_q  <= frame_end_i;
    end else if (cmd_i.finish) begin
      out_keyed_q <= keyed_hold_q;
      out_upd_q   <= 1'b1;
      out_done_q  <= 1'b1;
    end
  end

  assign keyed_o          = out_keyed_q;
  assign center_col_o     = track_col_q;
  assign center_row_o     = track_row_q;
  assign center_updated_o = out_upd_q;
  assign frame_done_o     = out_done_q;

endmodule
